@@ hdl/tipc_pkg.sv @@
// Shared constants for the trie prefix-count block: field widths, opcodes
// and default sizes. No dependencies.
package tipc_pkg;

  localparam int NODES_DEF      = 1024;
  localparam int ALPHABET_DEF   = 26;
  localparam int COUNT_BITS_DEF = 16;

  localparam int OPCODE_BITS = 2;
  localparam int LETTER_BITS = 5;
  localparam int COUNT_W     = 16;
  localparam int IN_DATA_W   = 8;
  localparam int IN_USER_W   = 3;

  typedef logic [OPCODE_BITS-1:0] opcode_t;

  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_EXACT  = 2'd1;
  localparam opcode_t OP_PREFIX = 2'd2;

endpackage

@@ hdl/trie_insert_prefix_count.sv @@
// Trie insert / exact-count / prefix-count engine, one letter per beat.
// An accepted beat passes the lookup stage, then the update stage; a word-ending beat's
// result is then registered in the output register, which drives out_tvalid. A new letter
// is not taken while the last one is in lookup, as its child-table read needs the cursor
// update of that lookup; a result held by out_tready low holds the next letter until
// the output register frees. Reset: synchronous, active low; afterwards a clearing pass
// over all NODES*ALPHABET child slots (26624 by default) zeroes both tables while in_tready stays low.
module trie_insert_prefix_count
  import tipc_pkg::*;
#(
  parameter int NODES      = NODES_DEF,
  parameter int ALPHABET   = ALPHABET_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // [4:0] letter, [7:5] zero fill
  input  logic [IN_USER_W-1:0] in_tuser,   // [1:0] opcode, [2] empty_word
  input  logic                 in_tlast,   // last letter of the word
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [COUNT_W-1:0]   out_tdata,  // [15:0] count
  output logic [0:0]           out_tuser   // [0] status (node pool overflow)
);

  localparam int CHILD_DEPTH = NODES * ALPHABET;
  localparam int NODE_BITS   = $clog2(NODES);
  localparam int FREE_BITS   = NODE_BITS + 1;
  localparam int SLOT_BITS   = $clog2(CHILD_DEPTH);
  localparam int CLR_BITS    = $clog2(CHILD_DEPTH + 1);
  localparam logic [FREE_BITS-1:0]  FREE_FULL = FREE_BITS'(NODES);
  localparam logic [CLR_BITS-1:0]   CLR_END   = CLR_BITS'(CHILD_DEPTH);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Node tables: child links per (node, letter), and {passing, ending} per node.
  logic [NODE_BITS-1:0]      child_mem [CHILD_DEPTH];
  logic [2*COUNT_BITS-1:0]   cnt_mem   [NODES];

  // Clearing pass after reset
  logic [CLR_BITS-1:0] clr_cnt_r;
  logic                clr_done;

  // Walk state
  logic [NODE_BITS-1:0] cursor_r, cursor_nxt;
  logic [FREE_BITS-1:0] free_r, free_nxt;
  logic                 miss_r, miss_nxt;
  logic                 ovf_r, ovf_nxt;

  // Lookup stage: child link read is in flight
  logic                 l_vld_r;
  opcode_t              l_op_r;
  logic                 l_last_r;
  logic                 l_empty_r;
  logic [SLOT_BITS-1:0] l_slot_r;
  logic [NODE_BITS-1:0] child_q_r;

  // Update stage: count read is in flight
  logic                  u_vld_r;
  opcode_t               u_op_r;
  logic                  u_out_r;
  logic                  u_ok_r;
  logic                  u_stat_r;
  logic                  u_pass_inc_r;
  logic [NODE_BITS-1:0]  u_node_r;
  logic [2*COUNT_BITS-1:0] cnt_q_r;

  // Output register
  logic                 out_valid_r;
  logic [COUNT_W-1:0]   out_data_r;
  logic                 out_stat_r;

  logic                 in_fire;
  logic                 u_stall;
  logic [LETTER_BITS-1:0] in_letter, letter_cl;
  logic [SLOT_BITS-1:0] in_slot;
  opcode_t              in_op;

  logic                 l_alloc, l_moved, l_ok, l_stat;
  logic [NODE_BITS-1:0] l_node, l_nx;

  logic [COUNT_BITS-1:0] pass_q, end_q, pass_new, end_new, u_result;
  logic                  u_end_inc, u_wr;

  assign clr_done = (clr_cnt_r == CLR_END);

  // Hold the update stage while its result cannot enter the output register.
  assign u_stall   = u_vld_r && u_out_r && out_valid_r && !out_tready;
  assign in_tready = clr_done && !l_vld_r && !u_stall;
  assign in_fire   = in_tvalid && in_tready;

  // Clamp out-of-range letters to the last one; treat opcode three as prefix.
  assign in_letter = in_tdata[LETTER_BITS-1:0];
  assign letter_cl = (in_letter >= LETTER_BITS'(ALPHABET)) ? LETTER_BITS'(ALPHABET - 1)
                                                          : in_letter;
  assign in_op     = (in_tuser[OPCODE_BITS-1:0] == OP_INSERT ||
                      in_tuser[OPCODE_BITS-1:0] == OP_EXACT) ? in_tuser[OPCODE_BITS-1:0]
                                                            : OP_PREFIX;
  assign in_slot   = SLOT_BITS'(cursor_r) * SLOT_BITS'(ALPHABET) + SLOT_BITS'(letter_cl);

  // Lookup stage: follow or create the child link, settle cursor and flags.
  always_comb begin
    miss_nxt   = miss_r;
    ovf_nxt    = ovf_r;
    cursor_nxt = cursor_r;
    free_nxt   = free_r;
    l_alloc    = 1'b0;
    l_moved    = 1'b0;
    l_node     = cursor_r;
    l_nx       = child_q_r;
    l_ok       = 1'b0;
    l_stat     = 1'b0;
    if (l_vld_r) begin
      if (l_empty_r) begin
        // Empty word acts on the root.
        miss_nxt   = 1'b0;
        ovf_nxt    = 1'b0;
        cursor_nxt = '0;
        l_node     = '0;
      end else if (!miss_r && !ovf_r) begin
        if (child_q_r == '0) begin
          if (l_op_r != OP_INSERT) begin
            miss_nxt = 1'b1;
          end else if (free_r == FREE_FULL) begin
            ovf_nxt = 1'b1;
          end else begin
            l_alloc  = 1'b1;
            l_nx     = free_r[NODE_BITS-1:0];
            free_nxt = free_r + FREE_BITS'(1);
          end
        end
        if (child_q_r != '0 || l_alloc) begin
          l_moved    = 1'b1;
          cursor_nxt = l_nx;
          l_node     = l_nx;
        end
      end
      l_ok   = !miss_nxt && !ovf_nxt;
      l_stat = ovf_nxt;
      // End of word: return the walk to the root.
      if (l_last_r) begin
        cursor_nxt = '0;
        miss_nxt   = 1'b0;
        ovf_nxt    = 1'b0;
      end
    end
  end

  // Update stage: saturating increments and the answer.
  assign pass_q    = cnt_q_r[2*COUNT_BITS-1:COUNT_BITS];
  assign end_q     = cnt_q_r[COUNT_BITS-1:0];
  assign pass_new  = (u_pass_inc_r && pass_q != COUNT_MAX) ? pass_q + COUNT_BITS'(1) : pass_q;
  assign u_end_inc = u_out_r && u_ok_r && (u_op_r == OP_INSERT);
  assign end_new   = (u_end_inc && end_q != COUNT_MAX) ? end_q + COUNT_BITS'(1) : end_q;
  assign u_wr      = u_vld_r && !u_stall && (u_pass_inc_r || u_end_inc);

  always_comb begin
    if (!u_ok_r) begin
      u_result = '0;
    end else begin
      unique case (u_op_r)
        OP_INSERT: u_result = end_new;
        OP_EXACT:  u_result = end_q;
        default:   u_result = pass_new;
      endcase
    end
  end

  // Child table: read on accept, write on allocation or while clearing.
  always_ff @(posedge clk) begin
    if (!clr_done) begin
      child_mem[clr_cnt_r[SLOT_BITS-1:0]] <= '0;
    end else if (l_alloc) begin
      child_mem[l_slot_r] <= l_nx;
    end
    if (in_fire) begin
      child_q_r <= child_mem[in_slot];
    end
  end

  // Count table: read in lookup, write back in update.
  always_ff @(posedge clk) begin
    if (!clr_done) begin
      if (clr_cnt_r < CLR_BITS'(NODES)) begin
        cnt_mem[clr_cnt_r[NODE_BITS-1:0]] <= '0;
      end
    end else if (u_wr) begin
      cnt_mem[u_node_r] <= {pass_new, end_new};
    end
    if (l_vld_r) begin
      cnt_q_r <= cnt_mem[l_node];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      cursor_r    <= '0;
      free_r      <= FREE_BITS'(1);
      miss_r      <= 1'b0;
      ovf_r       <= 1'b0;
      l_vld_r     <= 1'b0;
      u_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!clr_done) begin
        clr_cnt_r <= clr_cnt_r + CLR_BITS'(1);
      end
      cursor_r <= cursor_nxt;
      free_r   <= free_nxt;
      miss_r   <= miss_nxt;
      ovf_r    <= ovf_nxt;
      l_vld_r  <= in_fire;
      u_vld_r  <= l_vld_r || u_stall;
      if (u_vld_r && u_out_r && !u_stall) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_fire) begin
      l_op_r    <= in_op;
      l_last_r  <= in_tlast || in_tuser[2];
      l_empty_r <= in_tuser[2];
      l_slot_r  <= in_slot;
    end
    if (l_vld_r) begin
      u_op_r       <= l_op_r;
      u_out_r      <= l_last_r;
      u_ok_r       <= l_ok;
      u_stat_r     <= l_stat;
      u_pass_inc_r <= l_moved && (l_op_r == OP_INSERT);
      u_node_r     <= l_node;
    end
    if (u_vld_r && u_out_r && !u_stall) begin
      out_data_r <= COUNT_W'(u_result);
      out_stat_r <= u_stat_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_stat_r;

`ifndef NO_ASSERTIONS
  // Free counter never passes the pool size.
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FREE_FULL) else $error("free node counter past pool size");

  // The cursor always sits on an allocated node.
  a_cursor_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    FREE_BITS'(cursor_r) < free_r) else $error("cursor on unallocated node");

  // No beat is taken during the clearing pass.
  a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> clr_done) else $error("beat accepted while clearing");

  // The lookup stage is never held.
  a_lookup_one: assert property (@(posedge clk) disable iff (!rst_n)
    l_vld_r |=> !l_vld_r) else $error("lookup stage held");
`endif

endmodule

@@ test/trie_insert_prefix_count_tb.sv @@
// Self-checking testbench for trie_insert_prefix_count: directed words, random word streams
// under sender/receiver stalls and node pool exhaustion.
// Depends on tipc_pkg and the trie_insert_prefix_count RTL only.
`timescale 1ns / 1ps

module trie_insert_prefix_count_tb;
  import tipc_pkg::*;

  localparam int          COUNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
  // Opcode three has no name in the package; the block decodes it as a prefix count.
  localparam opcode_t     OP_RESERVED = 2'd3;
  // Letters used by the directed words. Codes at or above the alphabet size fold onto z.
  localparam logic [LETTER_BITS-1:0] LET_A   = 5'd0;
  localparam logic [LETTER_BITS-1:0] LET_B   = 5'd1;
  localparam logic [LETTER_BITS-1:0] LET_C   = 5'd2;
  localparam logic [LETTER_BITS-1:0] LET_Q   = 5'd16;
  localparam logic [LETTER_BITS-1:0] LET_Z   = 5'd25;
  localparam logic [LETTER_BITS-1:0] LET_ODD = 5'd30;
  localparam logic [LETTER_BITS-1:0] LET_TOP = 5'd31;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               status;
  } trie_answer_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata;   // [4:0] letter, [7:5] zero fill
  logic [IN_USER_W-1:0] in_tuser;   // [1:0] opcode, [2] empty_word
  logic                 in_tlast;   // last letter of the word
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [COUNT_W-1:0]   out_tdata;  // [15:0] count
  logic [0:0]           out_tuser;  // [0] status (node pool overflow)

  // Stall rates in percent, changed per test phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int beats_sent     = 0;
  int results_seen   = 0;
  int overflow_words = 0;
  int fail_count     = 0;

  // Expected answers, oldest first.
  trie_answer_t trie_answers[$];

  // Shadow trie: child links, per-node counts, allocator and the per-word walk state.
  int unsigned kid_node [NODES_DEF*ALPHABET_DEF];
  int unsigned pass_cnt [NODES_DEF];
  int unsigned end_cnt  [NODES_DEF];
  int unsigned free_next = 1;
  int unsigned cur_node  = 0;
  bit          word_missed;
  bit          word_overflowed;

  trie_insert_prefix_count u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop. Sized for the clearing pass plus a couple of thousand beats under the
  // heaviest stalls, several times over.
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d answers still pending", $realtime, trie_answers.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned sat_bump(input int unsigned v);
    return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
  endfunction

  // Advance the shadow trie by one accepted beat; queue the answer when the word ends.
  function automatic void trie_walk_beat(input opcode_t op, input logic [LETTER_BITS-1:0] letter,
                                         input bit is_last, input bit is_empty);
    opcode_t      op_eff;
    int unsigned  sym;
    int unsigned  nx;
    int unsigned  slot;
    bit           word_done;
    trie_answer_t ans;
    op_eff    = (op == OP_RESERVED) ? OP_PREFIX : op;
    sym       = (letter >= ALPHABET_DEF) ? ALPHABET_DEF - 1 : letter;
    word_done = is_last;
    if (is_empty) begin
      // Empty word: act on the root and close the word whatever tlast says.
      cur_node        = 0;
      word_missed     = 1'b0;
      word_overflowed = 1'b0;
      word_done       = 1'b1;
    end else if (!word_missed && !word_overflowed) begin
      slot = cur_node * ALPHABET_DEF + sym;
      nx   = kid_node[slot];
      if (nx == 0) begin
        if (op_eff != OP_INSERT) begin
          word_missed = 1'b1;
        end else if (free_next >= NODES_DEF) begin
          word_overflowed = 1'b1;
        end else begin
          nx             = free_next;
          kid_node[slot] = nx;
          free_next++;
        end
      end
      if (nx != 0) begin
        cur_node = nx;
        if (op_eff == OP_INSERT) pass_cnt[cur_node] = sat_bump(pass_cnt[cur_node]);
      end
    end
    if (!word_done) return;
    if (word_missed || word_overflowed) begin
      ans.count = '0;
    end else if (op_eff == OP_INSERT) begin
      end_cnt[cur_node] = sat_bump(end_cnt[cur_node]);
      ans.count = end_cnt[cur_node][COUNT_W-1:0];
    end else if (op_eff == OP_EXACT) begin
      ans.count = end_cnt[cur_node][COUNT_W-1:0];
    end else begin
      ans.count = pass_cnt[cur_node][COUNT_W-1:0];
    end
    ans.status = word_overflowed;
    if (word_overflowed) overflow_words++;
    trie_answers.insert(trie_answers.size(), ans);
    cur_node        = 0;
    word_missed     = 1'b0;
    word_overflowed = 1'b0;
  endfunction

  // Drive one letter beat and hold it until the block takes it. Called right after a
  // rising edge; leaves tvalid high so back-to-back beats never drop it.
  task automatic send_letter(input opcode_t op, input logic [LETTER_BITS-1:0] letter,
                             input bit is_last, input bit is_empty);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-LETTER_BITS){1'b0}}, letter};
    in_tuser  <= {is_empty, op};
    in_tlast  <= is_last;
    @(posedge clk);
    // tready stays low through the post-reset clearing pass, so this also covers it.
    while (in_tready !== 1'b1) @(posedge clk);
    trie_walk_beat(op, letter, is_last, is_empty);
    beats_sent++;
  endtask

  // Drop tvalid and wait for every queued answer to come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (trie_answers.size() != 0) @(posedge clk);
  endtask

  // Result side: check each accepted beat against the oldest answer, then redraw tready.
  always @(posedge clk) begin : check_out
    trie_answer_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      results_seen++;
      if (trie_answers.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, got count %0d status %0d",
                 $realtime, out_tdata, out_tuser);
      end else begin
        want = trie_answers.pop_front();
        if (out_tdata !== want.count) begin
          fail_count++;
          $display("%0t: count mismatch, expected %0d, got %0d",
                   $realtime, want.count, out_tdata);
        end
        if (out_tuser[0] !== want.status) begin
          fail_count++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $realtime, want.status, out_tuser[0]);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hand-picked words on a fresh trie: empty words, alphabet extremes, folded letters,
  // opcode three, a missing link, mixed opcodes and an empty beat inside a word.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_letter(OP_INSERT,   LET_TOP, 1'b1, 1'b1);  // empty insert bumps root end count
    send_letter(OP_EXACT,    LET_Q,   1'b0, 1'b1);  // empty exact; tlast ignored
    send_letter(OP_PREFIX,   LET_A,   1'b1, 1'b1);  // root passing count stays zero
    send_letter(OP_INSERT,   LET_A,   1'b1, 1'b0);  // "a"
    send_letter(OP_INSERT,   LET_Z,   1'b1, 1'b0);  // "z"
    send_letter(OP_INSERT,   LET_TOP, 1'b1, 1'b0);  // out of range folds onto "z"
    send_letter(OP_EXACT,    LET_ODD, 1'b1, 1'b0);
    send_letter(OP_RESERVED, LET_Z,   1'b1, 1'b0);  // decodes as prefix count
    send_letter(OP_INSERT,   LET_A,   1'b0, 1'b0);  // "ab"
    send_letter(OP_INSERT,   LET_B,   1'b1, 1'b0);
    send_letter(OP_PREFIX,   LET_A,   1'b1, 1'b0);
    send_letter(OP_EXACT,    LET_Q,   1'b0, 1'b0);  // missing link: rest of word skipped
    send_letter(OP_INSERT,   LET_A,   1'b0, 1'b0);
    send_letter(OP_EXACT,    LET_Z,   1'b1, 1'b0);
    send_letter(OP_INSERT,   LET_A,   1'b0, 1'b0);  // mixed: walk by insert, answer exact
    send_letter(OP_EXACT,    LET_B,   1'b1, 1'b0);
    send_letter(OP_INSERT,   LET_C,   1'b0, 1'b0);  // empty beat cuts the word short
    send_letter(OP_PREFIX,   LET_B,   1'b0, 1'b1);
    send_letter(OP_PREFIX,   LET_C,   1'b1, 1'b0);
    send_letter(OP_EXACT,    LET_A,   1'b0, 1'b0);  // exact prefix walk, insert at the end
    send_letter(OP_INSERT,   LET_C,   1'b1, 1'b0);
    settle();
  endtask

  // Random word stream. Most words are well formed over a three-letter alphabet so that
  // queries hit; the rest use every letter code, and a few beats are strays.
  task automatic test_random_words(input int send_pct, input int recv_pct, input int beats);
    int      stop_at;
    int      pick;
    int      len;
    int      span;
    opcode_t wop;
    opcode_t bop;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // Stray or empty beat with any field combination.
        send_letter(opcode_t'($urandom_range(3)), LETTER_BITS'($urandom_range(31)),
                    1'($urandom_range(1)), (pick < 4) ? 1'b1 : 1'($urandom_range(1)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 45)      wop = OP_INSERT;
        else if (pick < 68) wop = OP_EXACT;
        else if (pick < 92) wop = OP_PREFIX;
        else                wop = OP_RESERVED;
        len  = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(5, 1);
        span = ($urandom_range(9) < 7) ? 2 : 31;
        for (int i = 0; i < len; i++) begin
          bop = wop;
          if (i < len - 1 && $urandom_range(9) == 0) bop = opcode_t'($urandom_range(3));
          send_letter(bop, LETTER_BITS'($urandom_range(span)), i == len - 1, 1'b0);
        end
      end
    end
    settle();
  endtask

  // Fill the node pool with long fresh words, then insert past the end of it.
  task automatic test_pool_overflow();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (free_next < NODES_DEF) begin
      for (int i = 0; i < 8; i++)
        send_letter(OP_INSERT, LETTER_BITS'($urandom_range(25)), i == 7, 1'b0);
    end
    repeat (4) begin
      for (int i = 0; i < 5; i++)
        send_letter(OP_INSERT, LETTER_BITS'($urandom_range(25)), i == 4, 1'b0);
    end
    // Overflow partway, then query beats that must be skipped.
    send_letter(OP_INSERT, LETTER_BITS'($urandom_range(25)), 1'b0, 1'b0);
    send_letter(OP_INSERT, LETTER_BITS'($urandom_range(25)), 1'b0, 1'b0);
    send_letter(OP_PREFIX, LETTER_BITS'($urandom_range(25)), 1'b0, 1'b0);
    send_letter(OP_EXACT,  LETTER_BITS'($urandom_range(25)), 1'b1, 1'b0);
    // Existing paths still insert and answer once the flag clears.
    send_letter(OP_INSERT, LET_A, 1'b1, 1'b0);
    send_letter(OP_PREFIX, LET_A, 1'b0, 1'b0);
    send_letter(OP_PREFIX, LET_B, 1'b1, 1'b0);
    settle();
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    in_tlast  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_words(11, 67, 160);
    test_random_words(67, 11, 160);
    test_random_words(0, 0, 160);
    test_pool_overflow();

    // Give the output pipe time to show any stray result.
    repeat (8) @(posedge clk);
    if (trie_answers.size() != 0) begin
      fail_count += trie_answers.size();
      $display("%0t: %0d expected answers never arrived", $realtime, trie_answers.size());
    end

    $display("Covered %0d letter beats and %0d checked results over %0d allocated nodes,",
             beats_sent, results_seen, free_next);
    $display("including %0d words that ran into a full node pool.", overflow_words);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tipc_pkg.sv
hdl/trie_insert_prefix_count.sv
test/trie_insert_prefix_count_tb.sv
